// ===== sv/mcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpt_pkg: shared definitions for the multi-channel periodic timer
// Sizes, codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mcpt_pkg;

  localparam int CHANNELS    = 8;
  localparam int PERIOD_BITS = 16;

  localparam int CNT_W  = $clog2(CHANNELS + 1);
  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STEP_W = $clog2(PERIOD_BITS);

  // Widths of the result ports and the interval input
  localparam int MASK_W   = 8;
  localparam int BASE_W   = 16;
  localparam int COUNT_W  = 4;
  localparam int STATUS_W = 2;
  localparam int INTV_W   = 16;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_ZERO = 2'd2
  } status_t;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef struct packed {
    logic    capture;     // latch the item, clear mask and index
    logic    append;      // store new period, bump count, seed gcd operands
    logic    div_gcd;     // start divider on gcd operands
    logic    gcd_step;    // a <= b, b <= a mod b
    logic    set_base;    // base <= a
    logic    div_quot;    // start divider on period[idx] / base
    logic    quot_write;  // store quotient and restart countdown of idx
    logic    tick_step;   // service countdown of idx
    logic    idx_inc;     // advance channel index
    logic    emit;        // load result registers and pulse done
    status_t emit_status;
  } cmd_t;

  typedef struct packed {
    logic op_tick;
    logic full;
    logic zero_interval;
    logic no_channels;
    logic gcd_done;
    logic div_done;
    logic idx_last;
  } stat_t;

endpackage

// ===== sv/mcpt_div.sv =====
// ----------------------------------------------------------------------------
// mcpt_div: iterative restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module mcpt_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [mcpt_pkg::PERIOD_BITS-1:0] dividend,
  input  logic [mcpt_pkg::PERIOD_BITS-1:0] divisor,
  output logic                             done,
  output logic [mcpt_pkg::PERIOD_BITS-1:0] quotient,
  output logic [mcpt_pkg::PERIOD_BITS-1:0] remainder
);

  localparam int W      = mcpt_pkg::PERIOD_BITS;
  localparam int STEP_W = mcpt_pkg::STEP_W;

  logic              running;
  logic [STEP_W-1:0] step;
  logic [W-1:0]      dvs;
  logic [W-1:0]      quo;
  logic [W-1:0]      rem;
  logic [W:0]        shifted;
  logic [W:0]        diff;

  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= running && (step == '0);
      if (start) begin
        running <= 1'b1;
        step    <= STEP_W'(W - 1);
      end else if (running) begin
        if (step == '0) begin
          running <= 1'b0;
        end else begin
          step <= step - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      quo <= dividend;
      rem <= '0;
    end else if (running) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== sv/mcpt_datapath.sv =====
// ----------------------------------------------------------------------------
// mcpt_datapath: channel tables, base period, gcd operands and result regs
// Executes one controller command set per cycle; shares one divider.
// ----------------------------------------------------------------------------
module mcpt_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           opcode,
  input  logic [mcpt_pkg::INTV_W-1:0]    interval,
  input  mcpt_pkg::cmd_t                 cmd,
  output mcpt_pkg::stat_t                stat,
  output logic                           done,
  output logic [mcpt_pkg::MASK_W-1:0]    fired_mask,
  output logic [mcpt_pkg::BASE_W-1:0]    base_period,
  output logic [mcpt_pkg::COUNT_W-1:0]   channel_count,
  output logic [mcpt_pkg::STATUS_W-1:0]  status
);

  localparam int CHANNELS = mcpt_pkg::CHANNELS;
  localparam int W        = mcpt_pkg::PERIOD_BITS;
  localparam int CNT_W    = mcpt_pkg::CNT_W;
  localparam int IDX_W    = mcpt_pkg::IDX_W;
  localparam int MASK_W   = mcpt_pkg::MASK_W;
  localparam int BASE_W   = mcpt_pkg::BASE_W;
  localparam int COUNT_W  = mcpt_pkg::COUNT_W;
  localparam int MASK_PW  = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;
  localparam int BASE_PW  = (W > BASE_W) ? W : BASE_W;
  localparam int COUNT_PW = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  mcpt_pkg::opcode_t  op_q;
  logic [W-1:0]        intv_q;
  logic [CNT_W-1:0]    count;
  logic [W-1:0]        base;
  logic [W-1:0]        ga;
  logic [W-1:0]        gb;
  logic [IDX_W-1:0]    idx;
  logic [CHANNELS-1:0] mask;
  logic [CHANNELS-1:0] mask_upd;
  logic [CHANNELS-1:0] fire_bit;

  logic [W-1:0] period [CHANNELS];
  logic [W-1:0] quot   [CHANNELS];
  logic [W-1:0] cd     [CHANNELS];

  logic [W-1:0] cd_cur;
  logic         cd_zero;
  logic [W-1:0] cd_new;

  logic         div_start;
  logic [W-1:0] div_dividend;
  logic [W-1:0] div_divisor;
  logic         div_done;
  logic [W-1:0] div_quot;
  logic [W-1:0] div_rem;

  mcpt_pkg::status_t   res_status;
  logic [CHANNELS-1:0] res_mask;
  logic [W-1:0]        res_base;
  logic [CNT_W-1:0]    res_count;

  logic [MASK_PW-1:0]  mask_pad;
  logic [BASE_PW-1:0]  base_pad;
  logic [COUNT_PW-1:0] count_pad;

  // Shared divider: Euclid remainders, then per-channel quotients
  assign div_start    = cmd.div_gcd || cmd.div_quot;
  assign div_dividend = cmd.div_gcd ? ga : period[idx];
  assign div_divisor  = cmd.div_gcd ? gb : base;

  mcpt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Countdown service for the visited channel: reload on zero, then count down
  assign cd_cur  = cd[idx];
  assign cd_zero = (cd_cur == '0);
  assign cd_new  = cd_zero ? (quot[idx] - W'(1)) : (cd_cur - W'(1));

  always_comb begin
    fire_bit      = '0;
    fire_bit[idx] = 1'b1;
  end

  assign mask_upd = (cmd.tick_step && cd_zero) ? (mask | fire_bit) : mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      base  <= W'(1);
      idx   <= '0;
      mask  <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.capture) begin
        idx  <= '0;
        mask <= '0;
      end else begin
        mask <= mask_upd;
        if (cmd.idx_inc) begin
          idx <= idx + IDX_W'(1);
        end
      end
      if (cmd.append) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.set_base) begin
        base <= ga;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= mcpt_pkg::opcode_t'(opcode);
      intv_q <= W'(interval);
    end
    if (cmd.append) begin
      period[count[IDX_W-1:0]] <= intv_q;
      ga <= (count == '0) ? intv_q : base;
      gb <= (count == '0) ? '0 : intv_q;
    end else if (cmd.gcd_step) begin
      ga <= gb;
      gb <= div_rem;
    end
    if (cmd.quot_write) begin
      quot[idx] <= div_quot;
      cd[idx]   <= div_quot;
    end else if (cmd.tick_step) begin
      cd[idx] <= cd_new;
    end
    if (cmd.emit) begin
      res_status <= cmd.emit_status;
      res_mask   <= mask_upd;
      res_base   <= base;
      res_count  <= count;
    end
  end

  assign stat.op_tick       = (op_q == mcpt_pkg::OP_TICK);
  assign stat.full          = (count == CNT_W'(CHANNELS));
  assign stat.zero_interval = (intv_q == '0);
  assign stat.no_channels   = (count == '0);
  assign stat.gcd_done      = (gb == '0);
  assign stat.div_done      = div_done;
  assign stat.idx_last      = ((CNT_W'(idx) + CNT_W'(1)) == count);

  assign mask_pad      = MASK_PW'(res_mask);
  assign base_pad      = BASE_PW'(res_base);
  assign count_pad     = COUNT_PW'(res_count);
  assign fired_mask    = mask_pad[MASK_W-1:0];
  assign base_period   = base_pad[BASE_W-1:0];
  assign channel_count = count_pad[COUNT_W-1:0];
  assign status        = res_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CHANNELS))
    else $error("channel count beyond table size");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> div_divisor != '0)
    else $error("divider started with zero divisor");

  a_tick_base: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_step |-> (base != '0 && count != '0))
    else $error("tick serviced without channels or base");

  a_mask_ok_only: assert property (@(posedge clk) disable iff (rst)
    done && res_status != mcpt_pkg::STATUS_OK |-> res_mask == '0)
    else $error("fired mask on a rejected add");

endmodule

// ===== sv/mcpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcpt_ctrl: sequencer for the periodic timer
// Decodes an item, runs Euclid and the quotient sweep or the tick sweep.
// ----------------------------------------------------------------------------
module mcpt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mcpt_pkg::stat_t stat,
  output mcpt_pkg::cmd_t  cmd,
  output logic            busy
);

  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_DECODE     = 7'b0000010,
    ST_GCD_CHECK  = 7'b0000100,
    ST_GCD_WAIT   = 7'b0001000,
    ST_QUOT_START = 7'b0010000,
    ST_QUOT_WAIT  = 7'b0100000,
    ST_TICK       = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.emit_status = mcpt_pkg::STATUS_OK;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (stat.op_tick) begin
          if (stat.no_channels) begin
            cmd.emit   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_TICK;
          end
        end else if (stat.full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = mcpt_pkg::STATUS_FULL;
          state_next      = ST_IDLE;
        end else if (stat.zero_interval) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = mcpt_pkg::STATUS_ZERO;
          state_next      = ST_IDLE;
        end else begin
          cmd.append = 1'b1;
          state_next = ST_GCD_CHECK;
        end
      end
      ST_GCD_CHECK: begin
        if (stat.gcd_done) begin
          cmd.set_base = 1'b1;
          state_next   = ST_QUOT_START;
        end else begin
          cmd.div_gcd = 1'b1;
          state_next  = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (stat.div_done) begin
          cmd.gcd_step = 1'b1;
          state_next   = ST_GCD_CHECK;
        end
      end
      ST_QUOT_START: begin
        cmd.div_quot = 1'b1;
        state_next   = ST_QUOT_WAIT;
      end
      ST_QUOT_WAIT: begin
        if (stat.div_done) begin
          cmd.quot_write = 1'b1;
          if (stat.idx_last) begin
            cmd.emit   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_QUOT_START;
          end
        end
      end
      ST_TICK: begin
        cmd.tick_step = 1'b1;
        if (stat.idx_last) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== sv/multi_channel_periodic_timer_top.sv =====
// ----------------------------------------------------------------------------
// multi_channel_periodic_timer_top: multi-channel periodic timer
// Keeps up to eight channel periods, a gcd base period and per-channel
// countdowns; answers every command beat with exactly one result beat.
// ----------------------------------------------------------------------------
// Usage: raise start with opcode and interval while busy is low; that edge
// takes the beat. An add (opcode 0) appends a channel, recomputes the base
// period as the gcd of all periods and restarts every countdown at
// period / base. A tick (opcode 1) stands for one base period: each channel
// whose countdown is zero sets its fired_mask bit and reloads, then every
// countdown steps down. Each command yields one result beat: done is high for
// exactly one cycle with fired_mask, base_period, channel_count and status,
// and the receiver cannot stall it, so capture the result while done is high.
// A full table (status 1) or a zero interval (status 2) leaves the state
// untouched. A tick visits each registered channel in turn (the channels are
// serviced one per cycle), with done raised in the cycle busy drops. An add
// runs on the shared one-bit-per-cycle divider: Euclid remainder rounds until
// the remainder is zero, then one quotient division per registered channel.
// Rejected adds and ticks with no channels emit their result straight from
// the decode state. A new command may be started in the same cycle that done
// is shown.
// ----------------------------------------------------------------------------
module multi_channel_periodic_timer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           opcode,
  input  logic [mcpt_pkg::INTV_W-1:0]    interval,
  output logic                           busy,
  output logic                           done,
  output logic [mcpt_pkg::MASK_W-1:0]    fired_mask,
  output logic [mcpt_pkg::BASE_W-1:0]    base_period,
  output logic [mcpt_pkg::COUNT_W-1:0]   channel_count,
  output logic [mcpt_pkg::STATUS_W-1:0]  status
);

  mcpt_pkg::cmd_t  cmd;
  mcpt_pkg::stat_t stat;

  // Sequencer: holds off new beats while a command is in flight
  mcpt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Tables, divider and result registers
  mcpt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .opcode        (opcode),
    .interval      (interval),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .fired_mask    (fired_mask),
    .base_period   (base_period),
    .channel_count (channel_count),
    .status        (status)
  );

endmodule
